>>> rtl/dmc_pkg.sv
package dmc_pkg;

	localparam int DMC_MAX_LINES  = 1024;
	localparam int DMC_ADDR_WIDTH = 32;

	localparam int ADDR_PORT_W = 32;
	localparam int LINE_CNT_W  = 11;
	localparam int LINE_IDX_W  = 10;
	localparam int CNT_W       = 32;

	localparam logic [LINE_CNT_W-1:0] LINE_CNT_RESET = 11'd1024;

	localparam logic ACT_ACCESS = 1'b0;
	localparam logic ACT_PROBE  = 1'b1;

	// controller to datapath
	typedef struct packed {
		logic clr_we;
		logic load;
		logic rd;
		logic commit;
	} dmc_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic clr_last;
		logic div_done;
	} dmc_stat_t;

endpackage

>>> rtl/dmc_ram.sv
module dmc_ram #(
	parameter int WIDTH = 33,
	parameter int DEPTH = 1024
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> rtl/dmc_div.sv
module dmc_div #(
	parameter int DIVIDEND_W = 32,
	parameter int DIVISOR_W  = 11
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [DIVIDEND_W-1:0] dividend,
	input  logic [DIVISOR_W-1:0]  divisor,
	output logic                  done,
	output logic [DIVIDEND_W-1:0] quotient,
	output logic [DIVISOR_W-1:0]  remainder
);

	localparam int CW = $clog2(DIVIDEND_W + 1);

	logic [DIVIDEND_W-1:0] quo_q;
	logic [DIVISOR_W-1:0]  rem_q;
	logic [DIVISOR_W-1:0]  div_q;
	logic [CW-1:0]         cnt_q;
	logic                  run_q;
	logic                  done_q;
	logic [DIVISOR_W:0]    trial;
	logic                  fits;

	// restoring division, one quotient bit per cycle
	assign trial = {rem_q, quo_q[DIVIDEND_W-1]};
	assign fits  = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CW'(DIVIDEND_W);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (run_q) begin
			quo_q <= {quo_q[DIVIDEND_W-2:0], fits};
			rem_q <= fits ? DIVISOR_W'(trial - {1'b0, div_q}) : trial[DIVISOR_W-1:0];
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

>>> rtl/dmc_datapath.sv
module dmc_datapath #(
	parameter int MAX_LINES  = dmc_pkg::DMC_MAX_LINES,
	parameter int ADDR_WIDTH = dmc_pkg::DMC_ADDR_WIDTH
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  dmc_pkg::dmc_cmd_t                   cmd,
	output dmc_pkg::dmc_stat_t                  st,
	input  logic                                action,
	input  logic [dmc_pkg::ADDR_PORT_W-1:0]     address,
	input  logic                                cfg_we,
	input  logic [dmc_pkg::LINE_CNT_W-1:0]      cfg_wdata,
	output logic                                done,
	output logic                                hit,
	output logic [dmc_pkg::LINE_IDX_W-1:0]      line_index,
	output logic [dmc_pkg::CNT_W-1:0]           hit_total,
	output logic [dmc_pkg::CNT_W-1:0]           miss_total,
	output logic [dmc_pkg::CNT_W-1:0]           access_total
);

	import dmc_pkg::*;

	localparam int AW    = ADDR_WIDTH < ADDR_PORT_W ? ADDR_WIDTH : ADDR_PORT_W;
	localparam int IDX_W = MAX_LINES > 1 ? $clog2(MAX_LINES) : 1;
	localparam int WORD_W = AW + 1;

	logic [LINE_CNT_W-1:0] line_count_q;
	logic [LINE_CNT_W-1:0] n_eff;
	logic                  action_q;
	logic [IDX_W-1:0]      clr_addr_q;
	logic [AW-1:0]         quo;
	logic [LINE_CNT_W-1:0] rem;
	logic [IDX_W-1:0]      idx;
	logic [WORD_W-1:0]     rd_word;
	logic                  hit_now;
	logic                  ram_we;
	logic [IDX_W-1:0]      ram_waddr;
	logic [WORD_W-1:0]     ram_wdata;
	logic                  done_q;
	logic                  hit_q;
	logic [LINE_IDX_W-1:0] idx_q;
	logic [CNT_W-1:0]      hit_cnt_q;
	logic [CNT_W-1:0]      miss_cnt_q;
	logic [CNT_W-1:0]      acc_cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_count_q <= LINE_CNT_RESET;
		end else if (cfg_we) begin
			line_count_q <= cfg_wdata;
		end
	end

	// zero acts as one, anything above the table size acts as the table size
	always_comb begin
		if (line_count_q == '0) begin
			n_eff = LINE_CNT_W'(1);
		end else if (int'(line_count_q) > MAX_LINES) begin
			n_eff = LINE_CNT_W'(MAX_LINES);
		end else begin
			n_eff = line_count_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			action_q <= action;
		end
	end

	dmc_div #(
		.DIVIDEND_W(AW),
		.DIVISOR_W (LINE_CNT_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.load),
		.dividend (address[AW-1:0]),
		.divisor  (n_eff),
		.done     (st.div_done),
		.quotient (quo),
		.remainder(rem)
	);

	assign idx = IDX_W'(rem);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
		end else if (cmd.clr_we) begin
			clr_addr_q <= clr_addr_q + 1'b1;
		end
	end

	assign st.clr_last = clr_addr_q == IDX_W'(MAX_LINES - 1);

	// word layout: valid bit on top of the tag
	assign hit_now   = rd_word[AW] && (rd_word[AW-1:0] == quo);
	assign ram_we    = cmd.clr_we || (cmd.commit && action_q == ACT_ACCESS && !hit_now);
	assign ram_waddr = cmd.clr_we ? clr_addr_q : idx;
	assign ram_wdata = cmd.clr_we ? '0 : {1'b1, quo};

	dmc_ram #(
		.WIDTH(WORD_W),
		.DEPTH(MAX_LINES)
	) u_tag_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (cmd.rd),
		.raddr(idx),
		.rdata(rd_word)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q     <= 1'b0;
			hit_cnt_q  <= '0;
			miss_cnt_q <= '0;
			acc_cnt_q  <= '0;
		end else begin
			done_q <= cmd.commit;
			if (cmd.commit && action_q == ACT_ACCESS) begin
				acc_cnt_q <= acc_cnt_q + 1'b1;
				if (hit_now) begin
					hit_cnt_q <= hit_cnt_q + 1'b1;
				end else begin
					miss_cnt_q <= miss_cnt_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			hit_q <= hit_now;
			idx_q <= LINE_IDX_W'(idx);
		end
	end

	assign done         = done_q;
	assign hit          = hit_q;
	assign line_index   = idx_q;
	assign hit_total    = hit_cnt_q;
	assign miss_total   = miss_cnt_q;
	assign access_total = acc_cnt_q;

	// lookup compares data that was read the cycle before
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> $past(cmd.rd))
		else $error("commit without a preceding tag read");

	// one item gives one result strobe
	assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("result strobe held for two cycles");

	// a probe leaves all counters alone
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && action_q == ACT_PROBE) |=> $stable(acc_cnt_q) && $stable(miss_cnt_q)
			&& $stable(hit_cnt_q))
		else $error("probe changed a counter");

endmodule

>>> rtl/dmc_ctrl.sv
module dmc_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  dmc_pkg::dmc_stat_t st,
	output dmc_pkg::dmc_cmd_t  cmd,
	output logic               busy
);

	import dmc_pkg::*;

	typedef enum logic [3:0] {
		ST_CLEAR = 4'b0001,
		ST_IDLE  = 4'b0010,
		ST_DIV   = 4'b0100,
		ST_CMP   = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clr_we = 1'b1;
				if (st.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = ST_DIV;
				end
			end
			ST_DIV: begin
				// tag read goes out as soon as index and tag are known
				if (st.div_done) begin
					cmd.rd  = 1'b1;
					state_d = ST_CMP;
				end
			end
			ST_CMP: begin
				cmd.commit = 1'b1;
				state_d    = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign busy = state_q != ST_IDLE;

	assert property (@(posedge clk) disable iff (!arst_n)
		st.div_done |-> state_q == ST_DIV)
		else $error("divider finished outside of a lookup");

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> !cmd.clr_we && !cmd.commit)
		else $error("new item overlaps clear or commit");

endmodule

>>> rtl/direct_mapped_cache_tag_lookup.sv
// channel   direction  handshake             payload
// command   in         start, busy           action, address
// result    out        done (strobe)         hit, line_index, hit_total, miss_total,
//                                            access_total
// config    in         cfg_we                cfg_wdata (line_count)
//
// an item is accepted, then the iterative divider yields one quotient bit per cycle and
// flags done with the last bit; the tag read follows, then the compare/update step.
// busy falls in the cycle the strobe shows, so the next item can be accepted at the
// edge that ends the strobe. after reset the tag store is swept clear, with busy high.
// the result is shown for one cycle only; the receiver cannot stall it.
module direct_mapped_cache_tag_lookup #(
	parameter int MAX_LINES  = dmc_pkg::DMC_MAX_LINES,
	parameter int ADDR_WIDTH = dmc_pkg::DMC_ADDR_WIDTH
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic                            action,
	input  logic [dmc_pkg::ADDR_PORT_W-1:0] address,
	output logic                            done,
	output logic                            hit,
	output logic [dmc_pkg::LINE_IDX_W-1:0]  line_index,
	output logic [dmc_pkg::CNT_W-1:0]       hit_total,
	output logic [dmc_pkg::CNT_W-1:0]       miss_total,
	output logic [dmc_pkg::CNT_W-1:0]       access_total,
	input  logic                            cfg_we,
	input  logic [dmc_pkg::LINE_CNT_W-1:0]  cfg_wdata
);

	import dmc_pkg::*;

	dmc_cmd_t  cmd;
	dmc_stat_t st;

	dmc_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.st    (st),
		.cmd   (cmd),
		.busy  (busy)
	);

	dmc_datapath #(
		.MAX_LINES (MAX_LINES),
		.ADDR_WIDTH(ADDR_WIDTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.st          (st),
		.action      (action),
		.address     (address),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.done        (done),
		.hit         (hit),
		.line_index  (line_index),
		.hit_total   (hit_total),
		.miss_total  (miss_total),
		.access_total(access_total)
	);

endmodule

>>> dv/tb_direct_mapped_cache_tag_lookup.sv
module tb_direct_mapped_cache_tag_lookup;
	timeunit 1ns;
	timeprecision 1ps;

	import dmc_pkg::*;

	typedef struct {
		bit                  hit;
		bit [LINE_IDX_W-1:0] line_index;
		bit [CNT_W-1:0]      hit_total;
		bit [CNT_W-1:0]      miss_total;
		bit [CNT_W-1:0]      access_total;
	} lookup_t;

	class cache_lookup_board;
		bit                  valid_bits[DMC_MAX_LINES];
		bit [CNT_W-1:0]      stored_tags[DMC_MAX_LINES];
		bit [CNT_W-1:0]      hits;
		bit [CNT_W-1:0]      misses;
		bit [CNT_W-1:0]      accesses;
		bit [LINE_CNT_W-1:0] lines;
		lookup_t             pending_lookups[$];
		int                  mismatch_count;

		function new();
			foreach (valid_bits[i]) valid_bits[i] = 1'b0;
			hits = '0;
			misses = '0;
			accesses = '0;
			lines = LINE_CNT_RESET;
			mismatch_count = 0;
		endfunction

		function void set_lines(bit [LINE_CNT_W-1:0] v);
			lines = v;
		endfunction

		// zero acts as one, anything above the table size as the table size
		function bit [31:0] active_lines();
			if (lines == 0) return 1;
			if (lines > DMC_MAX_LINES) return DMC_MAX_LINES;
			return lines;
		endfunction

		function void note_lookup(bit act, bit [ADDR_PORT_W-1:0] addr);
			bit [31:0] n;
			bit [31:0] idx;
			bit [31:0] tag;
			lookup_t   res;
			n = active_lines();
			idx = addr % n;
			tag = addr / n;
			res.hit = valid_bits[idx] && stored_tags[idx] == tag;
			if (act == ACT_ACCESS) begin
				accesses++;
				if (res.hit) begin
					hits++;
				end else begin
					misses++;
					stored_tags[idx] = tag;
					valid_bits[idx] = 1'b1;
				end
			end
			res.line_index = idx[LINE_IDX_W-1:0];
			res.hit_total = hits;
			res.miss_total = misses;
			res.access_total = accesses;
			pending_lookups.push_back(res);
		endfunction

		task flag_mismatch(string what, bit [31:0] got, bit [31:0] want);
			$display("%0t mismatch %s: got %0h, want %0h", $realtime, what, got, want);
			mismatch_count++;
		endtask

		task check_lookup(lookup_t got);
			lookup_t want;
			if (pending_lookups.size() == 0) begin
				flag_mismatch("unexpected result, line", got.line_index, 0);
				return;
			end
			want = pending_lookups.pop_front();
			if (got.hit != want.hit) flag_mismatch("hit", got.hit, want.hit);
			if (got.line_index != want.line_index)
				flag_mismatch("line_index", got.line_index, want.line_index);
			if (got.hit_total != want.hit_total)
				flag_mismatch("hit_total", got.hit_total, want.hit_total);
			if (got.miss_total != want.miss_total)
				flag_mismatch("miss_total", got.miss_total, want.miss_total);
			if (got.access_total != want.access_total)
				flag_mismatch("access_total", got.access_total, want.access_total);
		endtask
	endclass

	logic                   clk;
	logic                   arst_n;
	logic                   start;
	logic                   busy;
	logic                   action;
	logic [ADDR_PORT_W-1:0] address;
	logic                   done;
	logic                   hit;
	logic [LINE_IDX_W-1:0]  line_index;
	logic [CNT_W-1:0]       hit_total;
	logic [CNT_W-1:0]       miss_total;
	logic [CNT_W-1:0]       access_total;
	logic                   cfg_we;
	logic [LINE_CNT_W-1:0]  cfg_wdata;

	cache_lookup_board board = new();
	bit [31:0]         addr_pool[16];
	lookup_t           seen;

	direct_mapped_cache_tag_lookup dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.action       (action),
		.address      (address),
		.done         (done),
		.hit          (hit),
		.line_index   (line_index),
		.hit_total    (hit_total),
		.miss_total   (miss_total),
		.access_total (access_total),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n && done) begin
			seen.hit = hit;
			seen.line_index = line_index;
			seen.hit_total = hit_total;
			seen.miss_total = miss_total;
			seen.access_total = access_total;
			board.check_lookup(seen);
		end
	end

	// called at a rising edge; returns at the edge that accepted the item, start left high
	task automatic send_lookup(bit act, bit [ADDR_PORT_W-1:0] addr);
		start <= 1'b1;
		action <= act;
		address <= addr;
		do @(posedge clk); while (busy);
		board.note_lookup(act, addr);
	endtask

	task automatic pause_sender(int cycles);
		start <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// wait for every result, then let the block settle
	task automatic drain_lookups();
		start <= 1'b0;
		while (board.pending_lookups.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic write_lines(bit [LINE_CNT_W-1:0] v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		board.set_lines(v);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic bit [31:0] pick_address();
		int        r;
		int        k;
		bit [31:0] a;
		r = $urandom_range(0, 99);
		k = $urandom_range(0, 15);
		if (r < 40) begin
			a = addr_pool[k];
		end else if (r < 55) begin
			// same line, different tag
			a = addr_pool[k] + board.active_lines() * $urandom_range(1, 4);
		end else if (r < 75) begin
			a = $urandom;
		end else if (r < 90) begin
			a = $urandom_range(0, 4095);
		end else begin
			a = ($urandom_range(0, 1) != 0) ? $urandom : $urandom_range(0, 8191);
			addr_pool[k] = a;
		end
		return a;
	endfunction

	initial begin
		bit [LINE_CNT_W-1:0] phase_lines[13];
		arst_n = 1'b0;
		start = 1'b0;
		action = ACT_ACCESS;
		address = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		foreach (addr_pool[i]) addr_pool[i] = $urandom_range(0, 4095);
		phase_lines = '{11'd1024, 11'd1, 11'd2, 11'd1023, 11'd1025, 11'd16, 11'd0,
			11'd512, 11'd7, 11'd2047, 11'd64, 11'd0, 11'd0};
		phase_lines[6] = $urandom_range(0, 2047);
		phase_lines[11] = $urandom_range(1, 300);
		phase_lines[12] = $urandom_range(0, 2047);
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// tag store is swept after reset
		drain_lookups();
		write_lines(LINE_CNT_RESET);

		send_lookup(ACT_ACCESS, 32'h0000_0000);
		send_lookup(ACT_ACCESS, 32'h0000_0000);
		send_lookup(ACT_PROBE,  32'h0000_0000);
		send_lookup(ACT_PROBE,  32'hFFFF_FFFF);
		send_lookup(ACT_ACCESS, 32'hFFFF_FFFF);
		send_lookup(ACT_PROBE,  32'hFFFF_FFFF);
		send_lookup(ACT_ACCESS, 32'h0000_0400);
		send_lookup(ACT_PROBE,  32'h0000_0000);
		send_lookup(ACT_ACCESS, 32'h8000_0000);
		send_lookup(ACT_ACCESS, 32'h7FFF_FFFF);
		drain_lookups();
		// zero line count behaves as a single line
		write_lines(11'd0);
		send_lookup(ACT_ACCESS, 32'h1234_5678);
		send_lookup(ACT_ACCESS, 32'h1234_5678);
		send_lookup(ACT_PROBE,  32'h0000_0005);
		drain_lookups();
		// oversized count clamps to the table size
		write_lines(11'd2047);
		send_lookup(ACT_PROBE,  32'h7FFF_FFFF);
		send_lookup(ACT_ACCESS, 32'h1234_5678);
		drain_lookups();
		// lines keep tags stored under the old divisor
		write_lines(11'd3);
		send_lookup(ACT_PROBE,  32'h8000_0000);
		send_lookup(ACT_ACCESS, 32'h0000_0003);
		send_lookup(ACT_PROBE,  32'hFFFF_FFFF);
		send_lookup(ACT_ACCESS, 32'h0000_0002);
		send_lookup(ACT_ACCESS, 32'h0000_0002);
		send_lookup(ACT_PROBE,  32'h0000_0000);
		drain_lookups();
		write_lines(11'd1);
		send_lookup(ACT_ACCESS, 32'h0000_0000);
		send_lookup(ACT_ACCESS, 32'hFFFF_FFFF);
		drain_lookups();

		foreach (phase_lines[p]) begin
			write_lines(phase_lines[p]);
			repeat (100) begin
				send_lookup(($urandom_range(0, 3) == 0) ? ACT_PROBE : ACT_ACCESS,
					pick_address());
				// phase 3 runs back to back
				if (p != 3 && $urandom_range(0, 99) < 60)
					pause_sender($urandom_range(1, 50));
			end
			drain_lookups();
		end

		if (board.mismatch_count == 0 && board.pending_lookups.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin
		#1000000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
